>>> sv/rlhc_pkg.sv
// rlhc_pkg: shared types and constants of the ranging line to heat cell block
// character codes, parser phases, status codes and heat scaling constants
// no dependencies
`default_nettype none

package rlhc_pkg;

  // payload widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned ZONE_W   = 6;
  localparam int unsigned XPOS_W   = 9;
  localparam int unsigned YPOS_W   = 11;
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned STATUS_W = 2;

  // grid geometry and zone limit
  localparam int unsigned GRID_COLUMNS = 4;
  localparam int unsigned CELL_PITCH   = 110;
  localparam int unsigned MAX_ZONE     = 63;

  // heat = 255 * distance / 2000, done by reciprocal multiply
  localparam int unsigned HEAT_SCALE = 255;
  localparam int unsigned HEAT_DIV   = 2000;
  localparam int unsigned HEAT_SHIFT = 30;
  localparam longint unsigned HEAT_RECIP =
    ((64'd1 << HEAT_SHIFT) + HEAT_DIV - 1) / HEAT_DIV;
  localparam longint unsigned HEAT_COEF = HEAT_SCALE * HEAT_RECIP;
  localparam int unsigned DIST_W = $clog2(HEAT_DIV);
  localparam int unsigned PROD_W = 40;

  // character codes
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // field within the line
  typedef enum logic [1:0] {
    FLD_ZONE = 2'd0,
    FLD_SKIP = 2'd1,
    FLD_DIST = 2'd2,
    FLD_DONE = 2'd3
  } field_t;

  // number reading phase
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  // summary of a finished line handed from parser to cell stage
  typedef struct packed {
    logic             dist_done;
    logic             dist_neg;
    logic [ACC_W-1:0] dist_val;
    logic             zone_seen;
    logic             zone_neg;
    logic [ACC_W-1:0] zone_val;
  } line_sum_t;

endpackage

`default_nettype wire

>>> sv/rlhc_if.sv
// rlhc_in_if and rlhc_out_if: valid/ready channels of the block
// depends on rlhc_pkg for payload widths
`default_nettype none

interface rlhc_in_if;
  import rlhc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rlhc_out_if;
  import rlhc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ZONE_W-1:0]   zone;
  logic [XPOS_W-1:0]   x_pos;
  logic [YPOS_W-1:0]   y_pos;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output zone, output x_pos, output y_pos, output red,
                  output green, output blue, output status, input ready);
  modport sink   (input valid, input zone, input x_pos, input y_pos, input red,
                  input green, input blue, input status, output ready);
endinterface

`default_nettype wire

>>> sv/ranging_line_to_heat_cell.sv
// ranging_line_to_heat_cell: top level, parser followed by cell result stage
// a line feed is held in the parser input register, then its word is loaded into the result register that drives out_ch
// throughput: one received byte per cycle while no line feed waits on a busy result slot
// a result waiting on out_ch stalls input only when the held byte is a line feed
// reset: synchronous active-low rst_n clears parser state and both valid flags
// depends on rlhc_pkg, rlhc_if, rlhc_parser and rlhc_cell
`default_nettype none

module ranging_line_to_heat_cell
  import rlhc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rlhc_in_if.sink    in_ch,
  rlhc_out_if.source out_ch
);

  logic      slot_free;
  logic      line_vld;
  line_sum_t line;

  // byte parser with input register
  rlhc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .line_vld  (line_vld),
    .line      (line)
  );

  // cell position, colour and result register
  rlhc_cell u_cell (
    .clk       (clk),
    .rst_n     (rst_n),
    .line_vld  (line_vld),
    .line      (line),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> sv/rlhc_parser.sv
// rlhc_parser: input register and per-byte text parser for one line
// depends on rlhc_pkg and rlhc_in_if
`default_nettype none

module rlhc_parser
  import rlhc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rlhc_in_if.sink    in_ch,
  input  wire logic  slot_free,
  output logic       line_vld,
  output line_sum_t  line
);

  logic [BYTE_W-1:0] byte_r;
  logic              byte_vld_r;
  field_t            fn_r, fn_nxt;
  phase_t            ph_r, ph_nxt;
  logic              vn_r, vn_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  zv_r, zv_nxt;
  logic [1:0]        zf_r, zf_nxt;
  logic              dn_r, dn_nxt;

  logic              is_lf, is_comma, is_digit, is_space, is_sign;
  logic [3:0]        dval;
  logic [ACC_W+3:0]  sum;
  logic [ACC_W-1:0]  acc_sat;
  logic              neg_nz;
  logic              proc_en;
  logic              take;

  // character classes of the held word
  assign is_lf    = (byte_r == CH_LF);
  assign is_comma = (byte_r == CH_COMMA);
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_space = (byte_r == CH_SPACE) || ((byte_r >= CH_TAB) && (byte_r <= CH_CR));
  assign is_sign  = (byte_r == CH_PLUS) || (byte_r == CH_MINUS);
  assign dval     = 4'(byte_r - CH_ZERO);

  // saturating decimal accumulate
  assign sum     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (ACC_W+4)'(dval);
  assign acc_sat = (sum > (ACC_W+4)'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  assign neg_nz  = vn_r && (acc_r != '0);

  // held word moves on unless it is a line feed and the result slot is busy
  assign proc_en     = byte_vld_r && (!is_lf || slot_free);
  assign in_ch.ready = !byte_vld_r || proc_en;
  assign line_vld    = proc_en && is_lf;

  // line summary, folding in a distance whose digits run up to the line feed
  always_comb begin
    line.zone_val  = zv_r;
    line.zone_seen = zf_r[0];
    line.zone_neg  = zf_r[1];
    line.dist_val  = acc_r;
    if (fn_r == FLD_DONE) begin
      line.dist_done = 1'b1;
      line.dist_neg  = dn_r;
    end else begin
      line.dist_done = (fn_r == FLD_DIST) && (ph_r == PH_DIGITS);
      line.dist_neg  = neg_nz;
    end
  end

  // parser next state
  always_comb begin
    fn_nxt  = fn_r;
    ph_nxt  = ph_r;
    vn_nxt  = vn_r;
    acc_nxt = acc_r;
    zv_nxt  = zv_r;
    zf_nxt  = zf_r;
    dn_nxt  = dn_r;
    take    = 1'b0;
    if (proc_en) begin
      if (is_lf) begin
        fn_nxt  = FLD_ZONE;
        ph_nxt  = PH_SKIP;
        vn_nxt  = 1'b0;
        acc_nxt = '0;
        zv_nxt  = '0;
        zf_nxt  = '0;
        dn_nxt  = 1'b0;
      end else if (is_comma) begin
        unique case (fn_r)
          FLD_ZONE: begin
            take    = (ph_r == PH_DIGITS);
            fn_nxt  = FLD_SKIP;
          end
          FLD_SKIP: begin
            fn_nxt  = FLD_DIST;
          end
          FLD_DIST: begin
            if (ph_r == PH_DIGITS) begin
              take = 1'b1;
            end else begin
              ph_nxt = PH_STOP;
            end
          end
          FLD_DONE: begin
          end
          default: begin
          end
        endcase
      end else if ((fn_r == FLD_ZONE) || (fn_r == FLD_DIST)) begin
        unique case (ph_r)
          PH_SKIP: begin
            priority if (is_space) begin
            end else if (is_sign) begin
              vn_nxt = (byte_r == CH_MINUS);
              ph_nxt = PH_SIGN;
            end else if (is_digit) begin
              acc_nxt = ACC_W'(dval);
              ph_nxt  = PH_DIGITS;
            end else begin
              ph_nxt = PH_STOP;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              acc_nxt = ACC_W'(dval);
              ph_nxt  = PH_DIGITS;
            end else begin
              ph_nxt = PH_STOP;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_sat;
            end else begin
              take = 1'b1;
            end
          end
          PH_STOP: begin
          end
          default: begin
          end
        endcase
      end

      // number taken: zone or distance
      if (take) begin
        ph_nxt = PH_STOP;
        if (fn_r == FLD_ZONE) begin
          zv_nxt = acc_r;
          zf_nxt = {neg_nz, 1'b1};
        end else begin
          dn_nxt = neg_nz;
          fn_nxt = FLD_DONE;
        end
      end

      // a comma leaving the zone field or field one starts a fresh number
      if (is_comma && ((fn_r == FLD_ZONE) || (fn_r == FLD_SKIP))) begin
        ph_nxt  = PH_SKIP;
        vn_nxt  = 1'b0;
        acc_nxt = '0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      byte_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_r  <= FLD_ZONE;
      ph_r  <= PH_SKIP;
      vn_r  <= 1'b0;
      acc_r <= '0;
      zv_r  <= '0;
      zf_r  <= '0;
      dn_r  <= 1'b0;
    end else begin
      fn_r  <= fn_nxt;
      ph_r  <= ph_nxt;
      vn_r  <= vn_nxt;
      acc_r <= acc_nxt;
      zv_r  <= zv_nxt;
      zf_r  <= zf_nxt;
      dn_r  <= dn_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/rlhc_cell.sv
// rlhc_cell: turns a line summary into cell position and colour, result register
// depends on rlhc_pkg and rlhc_out_if
`default_nettype none

module rlhc_cell
  import rlhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       line_vld,
  input  wire line_sum_t  line,
  output logic            slot_free,
  rlhc_out_if.source      out_ch
);

  logic                out_vld_r;
  logic [ZONE_W-1:0]   zone_r, zone_nxt;
  logic [XPOS_W-1:0]   x_r, x_nxt;
  logic [YPOS_W-1:0]   y_r, y_nxt;
  logic [COLOUR_W-1:0] red_r, red_nxt;
  logic [COLOUR_W-1:0] green_r, green_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [ZONE_W-1:0]   zone_w;
  logic [ZONE_W-1:0]   col;
  logic [ZONE_W-1:0]   row;
  logic [19:0]         x_full;
  logic [19:0]         y_full;
  logic                dist_small;
  logic [PROD_W-1:0]   prod;
  logic [COLOUR_W-1:0] heat;

  assign slot_free = !out_vld_r || out_ch.ready;

  // cell position on the grid
  assign zone_w = line.zone_val[ZONE_W-1:0];
  assign col    = zone_w % ZONE_W'(GRID_COLUMNS);
  assign row    = zone_w / ZONE_W'(GRID_COLUMNS);
  assign x_full = 20'(col) * 20'(CELL_PITCH);
  assign y_full = 20'(row) * 20'(CELL_PITCH);

  // heat by reciprocal multiply, only needed below the divisor
  assign dist_small = !line.dist_neg && (line.dist_val < ACC_W'(HEAT_DIV));
  assign prod       = PROD_W'(line.dist_val[DIST_W-1:0]) * PROD_W'(HEAT_COEF);
  assign heat       = prod[HEAT_SHIFT +: COLOUR_W];

  // status, position and colour
  always_comb begin
    zone_nxt   = '0;
    x_nxt      = '0;
    y_nxt      = '0;
    red_nxt    = '0;
    green_nxt  = '0;
    status_nxt = ST_OK;
    priority if (!line.dist_done || !line.zone_seen) begin
      status_nxt = ST_MISSING;
    end else if (line.zone_neg || (line.zone_val > ACC_W'(MAX_ZONE))) begin
      status_nxt = ST_RANGE;
    end else begin
      zone_nxt = zone_w;
      x_nxt    = x_full[XPOS_W-1:0];
      y_nxt    = y_full[YPOS_W-1:0];
      if (dist_small && (heat != '0)) begin
        red_nxt   = COLOUR_W'(HEAT_SCALE) - heat;
        green_nxt = heat;
      end else begin
        red_nxt   = '0;
        green_nxt = COLOUR_W'(HEAT_SCALE);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (slot_free) begin
      out_vld_r <= line_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (line_vld && slot_free) begin
      zone_r   <= zone_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.zone   = zone_r;
  assign out_ch.x_pos  = x_r;
  assign out_ch.y_pos  = y_r;
  assign out_ch.red    = red_r;
  assign out_ch.green  = green_r;
  assign out_ch.blue   = '0;
  assign out_ch.status = status_r;

endmodule

`default_nettype wire

>>> test/rlhc_checker.sv
`timescale 1ns / 1ps
// rlhc_checker: watches both channels of ranging_line_to_heat_cell, predicts each cell word
// from the received bytes and compares it field by field; depends on rlhc_pkg

module rlhc_checker
  import rlhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [BYTE_W-1:0]   in_byte,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [ZONE_W-1:0]   out_zone,
  input  wire logic [XPOS_W-1:0]   out_x_pos,
  input  wire logic [YPOS_W-1:0]   out_y_pos,
  input  wire logic [COLOUR_W-1:0] out_red,
  input  wire logic [COLOUR_W-1:0] out_green,
  input  wire logic [COLOUR_W-1:0] out_blue,
  input  wire logic [STATUS_W-1:0] out_status,
  output int                       fail_count,
  output int                       pending,
  output int                       cells_ok,
  output int                       cells_missing,
  output int                       cells_range
);

  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [XPOS_W-1:0]   x_pos;
    logic [YPOS_W-1:0]   y_pos;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [STATUS_W-1:0] status;
  } heat_cell_t;

  // predicted line parser state
  field_t           fld;
  phase_t           ph;
  logic             val_neg;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] zone_val;
  logic             zone_seen;
  logic             zone_neg;
  logic             dist_neg;

  heat_cell_t cell_q[$];
  logic       word_bad;

  task automatic start_value();
    ph      = PH_SKIP;
    val_neg = 1'b0;
    acc     = '0;
  endtask

  task automatic clear_line();
    fld       = FLD_ZONE;
    start_value();
    zone_val  = '0;
    zone_seen = 1'b0;
    zone_neg  = 1'b0;
    dist_neg  = 1'b0;
  endtask

  // close the number being read, as zone or as distance
  task automatic take_value();
    if (fld == FLD_ZONE) begin
      zone_val  = acc;
      zone_seen = 1'b1;
      zone_neg  = val_neg && (acc != 0);
    end else begin
      dist_neg = val_neg && (acc != 0);
      fld      = FLD_DONE;
    end
    ph = PH_STOP;
  endtask

  task automatic add_digit(input logic [BYTE_W-1:0] c);
    int unsigned v;
    v   = acc * 10 + (c - CH_ZERO);
    acc = (v > 65535) ? 16'hFFFF : v[ACC_W-1:0];
  endtask

  // string-to-int style reading of one character
  task automatic parse_char(input logic [BYTE_W-1:0] c);
    logic digit;
    logic space;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    case (ph)
      PH_SKIP: begin
        if (space) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          val_neg = (c == CH_MINUS);
          ph      = PH_SIGN;
        end else if (digit) begin
          acc = ACC_W'(c - CH_ZERO);
          ph  = PH_DIGITS;
        end else begin
          ph = PH_STOP;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          acc = ACC_W'(c - CH_ZERO);
          ph  = PH_DIGITS;
        end else begin
          ph = PH_STOP;
        end
      end
      PH_DIGITS: begin
        if (digit) add_digit(c);
        else take_value();
      end
      default: ;
    endcase
  endtask

  // one received byte; a line feed queues the predicted cell word
  task automatic take_byte(input logic [BYTE_W-1:0] c);
    heat_cell_t  pred;
    int unsigned heat;
    int unsigned zv;
    if (c != CH_LF) begin
      if (c == CH_COMMA) begin
        case (fld)
          FLD_ZONE: begin
            if (ph == PH_DIGITS) take_value();
            fld = FLD_SKIP;
            start_value();
          end
          FLD_SKIP: begin
            fld = FLD_DIST;
            start_value();
          end
          FLD_DIST: begin
            if (ph == PH_DIGITS) take_value();
            else ph = PH_STOP;
          end
          default: ;
        endcase
      end else if (fld == FLD_ZONE || fld == FLD_DIST) begin
        parse_char(c);
      end
    end else begin
      if ((fld == FLD_ZONE || fld == FLD_DIST) && ph == PH_DIGITS) take_value();
      pred = '0;
      if (fld != FLD_DONE || !zone_seen) begin
        pred.status = ST_MISSING;
      end else if (zone_neg || zone_val > MAX_ZONE) begin
        pred.status = ST_RANGE;
      end else begin
        zv          = zone_val;
        pred.status = ST_OK;
        pred.zone   = zv[ZONE_W-1:0];
        pred.x_pos  = XPOS_W'((zv % GRID_COLUMNS) * CELL_PITCH);
        pred.y_pos  = YPOS_W'((zv / GRID_COLUMNS) * CELL_PITCH);
        heat = dist_neg ? 0 : (HEAT_SCALE * acc) / HEAT_DIV;
        if (heat > 0 && heat < 255) begin
          pred.red   = COLOUR_W'(255 - heat);
          pred.green = COLOUR_W'(heat);
        end else begin
          pred.red   = '0;
          pred.green = 8'hFF;
        end
      end
      cell_q.insert(cell_q.size(), pred);
      clear_line();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("cell word field %s: expected %0d, got %0d", name, want, got);
      word_bad = 1'b1;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    heat_cell_t want;
    if (!rst_n) begin
      clear_line();
      cell_q.delete();
      fail_count    = 0;
      cells_ok      = 0;
      cells_missing = 0;
      cells_range   = 0;
    end else begin
      if (in_valid && in_ready) take_byte(in_byte);
      if (out_valid && out_ready) begin
        if (cell_q.size() == 0) begin
          $error("cell word arrived with none expected (zone %0d status %0d)",
                 out_zone, out_status);
          fail_count++;
        end else begin
          want     = cell_q.pop_front();
          word_bad = 1'b0;
          check_field("zone", want.zone, out_zone);
          check_field("x_pos", want.x_pos, out_x_pos);
          check_field("y_pos", want.y_pos, out_y_pos);
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("status", want.status, out_status);
          if (word_bad) fail_count++;
          case (want.status)
            ST_OK:      cells_ok++;
            ST_MISSING: cells_missing++;
            default:    cells_range++;
          endcase
        end
      end
    end
    pending = cell_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset and byte stimulus for ranging_line_to_heat_cell, with random idling
// depends on rlhc_pkg, rlhc_if, the block itself and rlhc_checker

module tb_top;
  import rlhc_pkg::*;

  logic clk;
  logic rst_n;

  rlhc_in_if  in_ch ();
  rlhc_out_if out_ch ();

  int fail_count;
  int pending;
  int cells_ok;
  int cells_missing;
  int cells_range;

  logic [BYTE_W-1:0] line_q[$];
  int                n_bytes;
  int                n_lines;
  logic              steady;

  ranging_line_to_heat_cell dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rlhc_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.rx_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_zone      (out_ch.zone),
    .out_x_pos     (out_ch.x_pos),
    .out_y_pos     (out_ch.y_pos),
    .out_red       (out_ch.red),
    .out_green     (out_ch.green),
    .out_blue      (out_ch.blue),
    .out_status    (out_ch.status),
    .fail_count    (fail_count),
    .pending       (pending),
    .cells_ok      (cells_ok),
    .cells_missing (cells_missing),
    .cells_range   (cells_range)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short idle runs, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int run;
    out_ch.ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 20);
      repeat (run) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
      end
      run = pick_gap();
      repeat (run) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
    end
  end

  // present one byte and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    n_bytes++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid   = 1'b0;
      in_ch.rx_byte = BYTE_W'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
    n_lines++;
  endtask

  // hold off the sender until every cell word has come out
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // append one byte to the line being built
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic push_num(input int unsigned v);
    logic [BYTE_W-1:0] rev[$];
    do begin
      rev.push_front(BYTE_W'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (rev[i]) put_byte(rev[i]);
  endtask

  task automatic push_space();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0:       put_byte(CH_TAB);
        1:       put_byte(CH_CR);
        2:       put_byte(8'd11);
        3:       put_byte(8'd12);
        default: put_byte(CH_SPACE);
      endcase
    end
  endtask

  task automatic push_sign(input int minus_pct, input int plus_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < minus_pct) put_byte(CH_MINUS);
    else if (r < minus_pct + plus_pct) put_byte(CH_PLUS);
  endtask

  // filler that is neither comma nor line feed nor digit
  task automatic push_junk(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) put_byte(BYTE_W'($urandom_range(65, 122)));
      else put_byte(BYTE_W'($urandom_range(128, 255)));
    end
  endtask

  // one random line: mostly well-formed records, some noise
  task automatic build_line();
    int r;
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 99) < 78) begin
      push_space();
      push_sign(8, 8);
      r = $urandom_range(0, 99);
      if (r < 80) push_num($urandom_range(0, 63));
      else if (r < 90) push_num($urandom_range(64, 999));
      else if (r < 95) push_num($urandom_range(65000, 999999));
      if ($urandom_range(0, 4) == 0) push_junk($urandom_range(1, 2));
      put_byte(CH_COMMA);
      push_junk($urandom_range(0, 4));
      if ($urandom_range(0, 19) != 0) begin
        put_byte(CH_COMMA);
        push_space();
        push_sign(10, 10);
        r = $urandom_range(0, 99);
        if (r < 60) push_num($urandom_range(0, 2100));
        else if (r < 75) push_num($urandom_range(0, 16));
        else if (r < 85) push_num($urandom_range(1990, 2010));
        else if (r < 92) push_num($urandom_range(2001, 999999));
        if ($urandom_range(0, 4) == 0) push_junk($urandom_range(1, 2));
        if ($urandom_range(0, 6) == 0) begin
          put_byte(CH_COMMA);
          push_num($urandom_range(0, 99));
        end
      end
    end else begin
      repeat ($urandom_range(0, 14)) begin
        r = $urandom_range(0, 9);
        if (r < 3) b = CH_COMMA;
        else if (r < 6) b = BYTE_W'($urandom_range(CH_ZERO, CH_NINE));
        else if (r < 7) b = ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_SPACE;
        else begin
          b = BYTE_W'($urandom_range(0, 254));
          if (b == CH_LF) b = 8'd255;
        end
        put_byte(b);
      end
    end
    put_byte(CH_LF);
  endtask

  // stimulus
  initial begin
    int rand_lines;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    n_bytes       = 0;
    n_lines       = 0;
    steady        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // empty line, negative zero, top zone with heat 254, both faults, negative zone
    push_text("\n");
    send_line();
    push_text("-0,,9\n");
    send_line();
    push_text("63,,1999\n");
    send_line();
    push_text("64,,\n");
    send_line();
    push_text("-1,,7\n");
    send_line();
    drain();

    rand_lines = 0;
    while (n_bytes < 400) begin
      steady = ($urandom_range(0, 4) == 0);
      build_line();
      send_line();
      rand_lines++;
      if (rand_lines % 15 == 0) drain();
    end
    steady = 1'b0;

    drain();
    repeat (5) @(negedge clk);
    $display("sent %0d bytes in %0d lines", n_bytes, n_lines);
    $display("cell words checked: %0d ok, %0d missing field, %0d zone out of range",
             cells_ok, cells_missing, cells_range);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rlhc_pkg.sv
sv/rlhc_if.sv
sv/rlhc_parser.sv
sv/rlhc_cell.sv
sv/ranging_line_to_heat_cell.sv
test/rlhc_checker.sv
test/tb_top.sv
